FILE: sv/fctab_pkg.sv
// ----------------------------------------------------------------------------
// fctab_pkg
// shared types and constants of the chain table engine
// ----------------------------------------------------------------------------
package fctab_pkg;

  localparam int unsigned TABLE_ENTRIES = 1024;
  localparam int unsigned BLK_W         = $clog2(TABLE_ENTRIES);
  localparam int unsigned ENT_W         = BLK_W + 1;
  localparam int unsigned CNT_W         = BLK_W + 1;

  localparam logic [ENT_W-1:0] END_MARK   = '1;
  localparam logic [ENT_W-1:0] FREE_ENTRY = '0;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TABLE_ENTRIES - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_ENTRIES);

  localparam logic [1:0] ACT_APPEND = 2'd0;
  localparam logic [1:0] ACT_LOOKUP = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;
  localparam logic [1:0] ACT_FIND   = 2'd3;

  typedef struct packed {
    logic [1:0]       action;
    logic [BLK_W-1:0] chain_block;
    logic             has_previous;
    logic [BLK_W-1:0] target_block;
    logic [BLK_W-1:0] logical_index;
  } fctab_req_t;

  typedef struct packed {
    logic             status;
    logic [BLK_W-1:0] result_block;
    logic [CNT_W-1:0] freed_count;
    logic             linked_to_previous;
  } fctab_rsp_t;

  typedef struct packed {
    logic             rd_en;
    logic [BLK_W-1:0] rd_addr;
    logic             wr_en;
    logic [BLK_W-1:0] wr_addr;
    logic [ENT_W-1:0] wr_data;
  } fctab_mem_req_t;

endpackage

FILE: sv/fctab_table.sv
// ----------------------------------------------------------------------------
// fctab_table
// chain table storage, one write and one registered read port
// ----------------------------------------------------------------------------
module fctab_table (
  input  logic                         clk_i,
  input  fctab_pkg::fctab_mem_req_t    mem_req_i,
  output logic [fctab_pkg::ENT_W-1:0]  rd_data_o
);
  import fctab_pkg::*;

  logic [ENT_W-1:0] mem_q [TABLE_ENTRIES];
  logic [ENT_W-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (mem_req_i.wr_en) begin
      mem_q[mem_req_i.wr_addr] <= mem_req_i.wr_data;
    end
    if (mem_req_i.rd_en) begin
      rd_q <= mem_q[mem_req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_q;

endmodule

FILE: sv/fctab_cnt_unit.sv
// ----------------------------------------------------------------------------
// fctab_cnt_unit
// shared increment and compare unit for steps, guards, counts and scan
// ----------------------------------------------------------------------------
module fctab_cnt_unit (
  input  logic [fctab_pkg::CNT_W-1:0] cnt_i,
  input  logic [fctab_pkg::CNT_W-1:0] cmp_i,
  output logic [fctab_pkg::CNT_W-1:0] inc_o,
  output logic                        eq_o
);
  import fctab_pkg::*;

  assign inc_o = cnt_i + CNT_W'(1);
  assign eq_o  = (cnt_i == cmp_i);

endmodule

FILE: sv/fctab_seq.sv
// ----------------------------------------------------------------------------
// fctab_seq
// sequencer: clearing pass, append, lookup walk, remove walk, free scan
// ----------------------------------------------------------------------------
module fctab_seq (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  fctab_pkg::fctab_req_t        in_req_i,
  input  logic [fctab_pkg::BLK_W-1:0]  first_data_i,
  input  logic                         out_free_i,
  output logic                         done_o,
  output fctab_pkg::fctab_rsp_t        rsp_o,
  output fctab_pkg::fctab_mem_req_t    mem_req_o,
  input  logic [fctab_pkg::ENT_W-1:0]  rd_data_i
);
  import fctab_pkg::*;

  localparam logic [3:0] S_CLEAR   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_AP_NB   = 4'd2;
  localparam logic [3:0] S_AP_RD   = 4'd3;
  localparam logic [3:0] S_AP_CHK  = 4'd4;
  localparam logic [3:0] S_LK_CHK  = 4'd5;
  localparam logic [3:0] S_RM_CHK  = 4'd6;
  localparam logic [3:0] S_FR_TEST = 4'd7;
  localparam logic [3:0] S_FR_WR   = 4'd8;
  localparam logic [3:0] S_FD_CHK  = 4'd9;
  localparam logic [3:0] S_FINISH  = 4'd10;

  logic [3:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [BLK_W-1:0] cur_q, cur_d;
  logic [ENT_W-1:0] next_q, next_d;
  fctab_req_t       req_q, req_d;
  fctab_rsp_t       res_q, res_d;

  logic [CNT_W-1:0] cmp_b;
  logic [CNT_W-1:0] cnt_inc;
  logic             cnt_eq;
  logic             rd_free;
  logic             rd_end;
  logic             start_hit;

  fctab_cnt_unit u_cnt (
    .cnt_i (cnt_q),
    .cmp_i (cmp_b),
    .inc_o (cnt_inc),
    .eq_o  (cnt_eq)
  );

  assign rd_free   = (rd_data_i == FREE_ENTRY);
  assign rd_end    = (rd_data_i == END_MARK);
  assign start_hit = (rd_data_i == {1'b0, req_q.target_block});

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cur_d      = cur_q;
    next_d     = next_q;
    req_d      = req_q;
    res_d      = res_q;
    mem_req_o  = '0;
    cmp_b      = CNT_LAST;
    in_ready_o = 1'b0;
    done_o     = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        mem_req_o.wr_en   = 1'b1;
        mem_req_o.wr_addr = cnt_q[BLK_W-1:0];
        mem_req_o.wr_data = FREE_ENTRY;
        if (cnt_eq) begin
          cnt_d   = '0;
          state_d = S_IDLE;
        end else begin
          cnt_d = cnt_inc;
        end
      end

      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          req_d           = in_req_i;
          cur_d           = in_req_i.chain_block;
          cnt_d           = '0;
          res_d           = '0;
          res_d.status    = 1'b1;
          mem_req_o.rd_en = 1'b1;
          unique case (in_req_i.action)
            ACT_APPEND: begin
              mem_req_o.rd_addr = in_req_i.target_block;
              state_d           = S_AP_NB;
            end
            ACT_LOOKUP: begin
              mem_req_o.rd_addr = in_req_i.chain_block;
              state_d           = S_LK_CHK;
            end
            ACT_REMOVE: begin
              mem_req_o.rd_addr = in_req_i.chain_block;
              state_d           = S_RM_CHK;
            end
            ACT_FIND: begin
              mem_req_o.rd_addr = first_data_i;
              cnt_d             = {1'b0, first_data_i};
              state_d           = S_FD_CHK;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end

      // new block must be free; it gets the end mark even if linking fails
      S_AP_NB: begin
        if (!rd_free) begin
          state_d = S_FINISH;
        end else begin
          mem_req_o.wr_en   = 1'b1;
          mem_req_o.wr_addr = req_q.target_block;
          mem_req_o.wr_data = END_MARK;
          if (req_q.has_previous) begin
            state_d = S_AP_RD;
          end else begin
            res_d.status = 1'b0;
            state_d      = S_FINISH;
          end
        end
      end

      S_AP_RD: begin
        mem_req_o.rd_en   = 1'b1;
        mem_req_o.rd_addr = req_q.chain_block;
        state_d           = S_AP_CHK;
      end

      S_AP_CHK: begin
        if (rd_end) begin
          mem_req_o.wr_en          = 1'b1;
          mem_req_o.wr_addr        = req_q.chain_block;
          mem_req_o.wr_data        = {1'b0, req_q.target_block};
          res_d.status             = 1'b0;
          res_d.linked_to_previous = 1'b1;
        end
        state_d = S_FINISH;
      end

      // rd_data holds the entry of cur, cnt counts links followed
      S_LK_CHK: begin
        cmp_b = {1'b0, req_q.logical_index};
        if ((cnt_q == '0) && rd_free) begin
          state_d = S_FINISH;
        end else if (cnt_eq) begin
          res_d.status       = 1'b0;
          res_d.result_block = cur_q;
          state_d            = S_FINISH;
        end else if (rd_free || rd_end) begin
          state_d = S_FINISH;
        end else begin
          cur_d             = rd_data_i[BLK_W-1:0];
          cnt_d             = cnt_inc;
          mem_req_o.rd_en   = 1'b1;
          mem_req_o.rd_addr = rd_data_i[BLK_W-1:0];
        end
      end

      // search for the start block, cnt is the step guard
      S_RM_CHK: begin
        if (rd_free || rd_end) begin
          if (cur_q == req_q.target_block) begin
            mem_req_o.wr_en   = 1'b1;
            mem_req_o.wr_addr = cur_q;
            mem_req_o.wr_data = FREE_ENTRY;
            res_d.status      = 1'b0;
            res_d.freed_count = CNT_W'(1);
          end
          state_d = S_FINISH;
        end else if (cur_q == req_q.target_block) begin
          mem_req_o.wr_en   = 1'b1;
          mem_req_o.wr_addr = cur_q;
          mem_req_o.wr_data = FREE_ENTRY;
          cnt_d             = CNT_W'(1);
          next_d            = rd_data_i;
          state_d           = S_FR_TEST;
        end else if (start_hit) begin
          mem_req_o.wr_en   = 1'b1;
          mem_req_o.wr_addr = cur_q;
          mem_req_o.wr_data = END_MARK;
          cnt_d             = '0;
          next_d            = rd_data_i;
          state_d           = S_FR_TEST;
        end else if (cnt_eq) begin
          state_d = S_FINISH;
        end else begin
          cur_d             = rd_data_i[BLK_W-1:0];
          cnt_d             = cnt_inc;
          mem_req_o.rd_en   = 1'b1;
          mem_req_o.rd_addr = rd_data_i[BLK_W-1:0];
        end
      end

      // free the rest of the chain, cnt is the freed count
      S_FR_TEST: begin
        cmp_b = CNT_FULL;
        if (!cnt_eq && (next_q != END_MARK) && (next_q != FREE_ENTRY)) begin
          mem_req_o.rd_en   = 1'b1;
          mem_req_o.rd_addr = next_q[BLK_W-1:0];
          state_d           = S_FR_WR;
        end else begin
          res_d.status      = 1'b0;
          res_d.freed_count = cnt_q;
          state_d           = S_FINISH;
        end
      end

      S_FR_WR: begin
        mem_req_o.wr_en   = 1'b1;
        mem_req_o.wr_addr = next_q[BLK_W-1:0];
        mem_req_o.wr_data = FREE_ENTRY;
        next_d            = rd_data_i;
        cnt_d             = cnt_inc;
        state_d           = S_FR_TEST;
      end

      // upward scan, no wrap, cnt is the entry address
      S_FD_CHK: begin
        if (rd_free) begin
          res_d.status       = 1'b0;
          res_d.result_block = cnt_q[BLK_W-1:0];
          state_d            = S_FINISH;
        end else if (cnt_eq) begin
          state_d = S_FINISH;
        end else begin
          cnt_d             = cnt_inc;
          mem_req_o.rd_en   = 1'b1;
          mem_req_o.rd_addr = cnt_inc[BLK_W-1:0];
        end
      end

      S_FINISH: begin
        if (out_free_i) begin
          done_o  = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    next_q <= next_d;
    req_q  <= req_d;
    res_q  <= res_d;
  end

  assign rsp_o = res_q;

endmodule

FILE: sv/fat_chain_table_engine_unit.sv
// ----------------------------------------------------------------------------
// fat_chain_table_engine_unit
// file allocation chain table: append, lookup, remove and free search
// ----------------------------------------------------------------------------
//
// channel   direction  handshake                    payload
// in        in         in_valid_i / in_ready_o      in_req_i  (fctab_req_t)
// out       out        out_valid_o / out_ready_i    out_rsp_o (fctab_rsp_t)
// cfg       in         cfg_valid_i / cfg_ready_o    cfg_data_i (first data entry)
//
// each request is paced by the single table read port walking one
// entry at a time: append reads the new block and, when linked, the chain
// block as well; lookup walks the links, find scans entries, remove
// searches entries and, when the chain is cut, the freeing walk clears each
// entry; after reset a clearing pass writes all 1024 entries free, with
// in_ready_o low; cfg writes are taken at any time
// one request in flight; the next is taken while a result waits in the
// output register, and the sequencer holds its result if that is still full
module fat_chain_table_engine_unit (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  fctab_pkg::fctab_req_t   in_req_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output fctab_pkg::fctab_rsp_t   out_rsp_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [9:0]              cfg_data_i
);
  import fctab_pkg::*;

  localparam logic [BLK_W-1:0] FIRST_DATA_RESET = BLK_W'(130);

  logic [BLK_W-1:0] first_data_q;
  logic             out_valid_q;
  fctab_rsp_t       out_rsp_q;

  logic             out_free;
  logic             seq_done;
  fctab_rsp_t       seq_rsp;
  fctab_mem_req_t   mem_req;
  logic [ENT_W-1:0] rd_data;

  // config register, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_data_q <= FIRST_DATA_RESET;
    end else if (cfg_valid_i) begin
      first_data_q <= cfg_data_i[BLK_W-1:0];
    end
  end

  // output register frees up in the same cycle it is taken
  assign out_free = !out_valid_q || out_ready_i;

  fctab_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_req_i     (in_req_i),
    .first_data_i (first_data_q),
    .out_free_i   (out_free),
    .done_o       (seq_done),
    .rsp_o        (seq_rsp),
    .mem_req_o    (mem_req),
    .rd_data_i    (rd_data)
  );

  fctab_table u_table (
    .clk_i     (clk_i),
    .mem_req_i (mem_req),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (seq_done) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload, loaded when the sequencer hands over
  always_ff @(posedge clk_i) begin
    if (seq_done) begin
      out_rsp_q <= seq_rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule
